[design/wfrm_pkg.sv]
package wfrm_pkg;

    // Window depth and field widths
    localparam int HISTORY_DEPTH = 16;
    localparam int IN_W          = 32;
    localparam int DT_W          = 31;
    localparam int RATE_W        = 14;
    localparam int TOTAL_W       = 63;
    localparam int GRADE_W       = 2;
    localparam int CFG_W         = 14;
    localparam int CFG_ADDR_W    = 1;

    // Derived storage widths
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = DT_W + $clog2(HISTORY_DEPTH);
    localparam int MS_PER_SECOND = 1000;
    localparam int NUM_W         = $clog2(MS_PER_SECOND * HISTORY_DEPTH + 1);
    localparam int QUO_W         = (NUM_W > RATE_W) ? NUM_W : RATE_W;
    localparam int CNT_W         = $clog2(SUM_W);
    localparam int RATE_MAX      = (1 << RATE_W) - 1;

    // Output word layout, lowest bit first
    localparam int RATE_LSB      = 0;
    localparam int DT_LSB        = RATE_LSB + RATE_W;
    localparam int TOTAL_LSB     = DT_LSB + DT_W;
    localparam int GRADE_LSB     = TOTAL_LSB + TOTAL_W;
    localparam int OUT_W         = GRADE_LSB + GRADE_W;
    localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BAD_RATE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_RATE = 1'b1;

    localparam logic [CFG_W-1:0] BAD_RATE_RESET  = 14'd30;
    localparam logic [CFG_W-1:0] WARN_RATE_RESET = 14'd55;

    typedef enum logic [GRADE_W-1:0] {
        GRADE_GOOD = 2'd0,
        GRADE_WARN = 2'd1,
        GRADE_BAD  = 2'd2
    } grade_t;

endpackage

[design/windowed_frame_rate_meter.sv]
// Channel | Dir | Handshake         | Payload (lowest bit first)
// s_*     | in  | s_tvalid/s_tready | s_tdata: dt_ms[31:0], signed
// m_*     | out | m_tvalid/m_tready | m_tdata: rate_fps, latest_dt_ms, total_frame_count, rate_grade
// cfg_*   | in  | cfg_we            | cfg_addr: register index, cfg_data[13:0]
//
// Each word passes through these steps before the next word is accepted:
// a bit-serial window sum update, a restoring division (one quotient bit per cycle),
// loading the output register, and taking a word.
// Reset clears the window state at once; a ring slot is read back only once the window is full.
// A result waits in the output register while the next word is processed; the block
// stalls only at the final step while that result is still unread.
module windowed_frame_rate_meter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // dt_ms[31:0]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [wfrm_pkg::IN_W-1:0]             s_tdata,
    // rate_fps, latest_dt_ms, total_frame_count, rate_grade, zero pad
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wfrm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [wfrm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [wfrm_pkg::CFG_W-1:0]            cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } state_t;

    // Control state
    state_t                              state_reg,    state_next;
    logic [wfrm_pkg::CNT_W-1:0]          cnt_reg,      cnt_next;
    logic [wfrm_pkg::SLOT_W-1:0]         slot_reg,     slot_next;
    logic [wfrm_pkg::FILL_W-1:0]         fill_reg,     fill_next;
    logic [wfrm_pkg::TOTAL_W-1:0]        life_reg,     life_next;
    logic [wfrm_pkg::SUM_W-1:0]          sum_reg,      sum_next;
    logic [wfrm_pkg::CFG_W-1:0]          bad_reg,      bad_next;
    logic [wfrm_pkg::CFG_W-1:0]          warn_reg,     warn_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [wfrm_pkg::OUT_TDATA_W-1:0]    m_tdata_reg,  m_tdata_next;

    // Datapath payload
    logic [wfrm_pkg::DT_W-1:0]           ring_mem [wfrm_pkg::HISTORY_DEPTH];
    logic [wfrm_pkg::DT_W-1:0]           dt_reg,       dt_next;
    logic [wfrm_pkg::SUM_W-1:0]          add_sh_reg,   add_sh_next;
    logic [wfrm_pkg::SUM_W-1:0]          sub_sh_reg,   sub_sh_next;
    logic                                carry_reg,    carry_next;
    logic                                borrow_reg,   borrow_next;
    logic [wfrm_pkg::SUM_W-1:0]          rem_reg,      rem_next;
    logic [wfrm_pkg::NUM_W-1:0]          quo_reg,      quo_next;

    logic                                s_acc;
    logic                                out_free;
    logic [wfrm_pkg::DT_W-1:0]           dt_in;
    logic [wfrm_pkg::DT_W-1:0]           dt_old;
    logic                                bit_s, bit_d, bit_o, bit_a, bit_r;
    logic [wfrm_pkg::SUM_W:0]            trial;
    logic                                q_bit;
    logic [wfrm_pkg::QUO_W-1:0]          quo_wide;
    logic [wfrm_pkg::RATE_W-1:0]         rate;
    wfrm_pkg::grade_t                    grade;
    logic [wfrm_pkg::FILL_W-1:0]         fill_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Clamp negatives to zero
    assign dt_in  = s_tdata[wfrm_pkg::IN_W-1] ? '0 : s_tdata[wfrm_pkg::DT_W-1:0];

    // The slot about to be overwritten only holds data once the window is full
    assign dt_old = (fill_reg == wfrm_pkg::FILL_W'(wfrm_pkg::HISTORY_DEPTH)) ?
                    ring_mem[slot_reg] : '0;

    assign fill_inc = (fill_reg == wfrm_pkg::FILL_W'(wfrm_pkg::HISTORY_DEPTH)) ?
                      fill_reg : fill_reg + wfrm_pkg::FILL_W'(1);

    // Serial update: sum + new - old, one bit per cycle, LSB first
    assign bit_s = sum_reg[0];
    assign bit_d = add_sh_reg[0];
    assign bit_o = sub_sh_reg[0];
    assign bit_a = bit_s ^ bit_d ^ carry_reg;
    assign bit_r = bit_a ^ bit_o ^ borrow_reg;

    // Restoring division step: shift in the next numerator bit, try subtract
    assign trial = {rem_reg, quo_reg[wfrm_pkg::NUM_W-1]} - {1'b0, sum_reg};
    assign q_bit = ~trial[wfrm_pkg::SUM_W];

    // Saturate the quotient, zero for an empty sum
    assign quo_wide = wfrm_pkg::QUO_W'(quo_reg);
    always_comb
    begin
        if (sum_reg == '0)
        begin
            rate = '0;
        end
        else if (quo_wide > wfrm_pkg::QUO_W'(wfrm_pkg::RATE_MAX))
        begin
            rate = wfrm_pkg::RATE_W'(wfrm_pkg::RATE_MAX);
        end
        else
        begin
            rate = wfrm_pkg::RATE_W'(quo_wide);
        end
    end

    // Bad is checked before warning
    always_comb
    begin
        if (rate < bad_reg)
        begin
            grade = wfrm_pkg::GRADE_BAD;
        end
        else if (rate < warn_reg)
        begin
            grade = wfrm_pkg::GRADE_WARN;
        end
        else
        begin
            grade = wfrm_pkg::GRADE_GOOD;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        life_next     = life_reg;
        sum_next      = sum_reg;
        bad_next      = bad_reg;
        warn_next     = warn_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        dt_next       = dt_reg;
        add_sh_next   = add_sh_reg;
        sub_sh_next   = sub_sh_reg;
        carry_next    = carry_reg;
        borrow_next   = borrow_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                wfrm_pkg::REG_BAD_RATE:  bad_next  = cfg_data;
                wfrm_pkg::REG_WARN_RATE: warn_next = cfg_data;
                default:                 ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    // Record the word, advance slot, fill and lifetime count
                    dt_next     = dt_in;
                    add_sh_next = wfrm_pkg::SUM_W'(dt_in);
                    sub_sh_next = wfrm_pkg::SUM_W'(dt_old);
                    carry_next  = 1'b0;
                    borrow_next = 1'b0;
                    rem_next    = '0;
                    fill_next   = fill_inc;
                    quo_next    = wfrm_pkg::NUM_W'(wfrm_pkg::MS_PER_SECOND * fill_inc);
                    slot_next   = (slot_reg == wfrm_pkg::SLOT_W'(wfrm_pkg::HISTORY_DEPTH - 1)) ?
                                  '0 : slot_reg + wfrm_pkg::SLOT_W'(1);
                    life_next   = (life_reg == wfrm_pkg::TOTAL_MAX) ?
                                  life_reg : life_reg + wfrm_pkg::TOTAL_W'(1);
                    cnt_next    = wfrm_pkg::CNT_W'(wfrm_pkg::SUM_W - 1);
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next    = {bit_r, sum_reg[wfrm_pkg::SUM_W-1:1]};
                add_sh_next = {1'b0, add_sh_reg[wfrm_pkg::SUM_W-1:1]};
                sub_sh_next = {1'b0, sub_sh_reg[wfrm_pkg::SUM_W-1:1]};
                carry_next  = (bit_s & bit_d) | (carry_reg & (bit_s ^ bit_d));
                borrow_next = (~bit_a & (bit_o | borrow_reg)) | (bit_o & borrow_reg);
                if (cnt_reg == '0)
                begin
                    cnt_next   = wfrm_pkg::CNT_W'(wfrm_pkg::NUM_W - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - wfrm_pkg::CNT_W'(1);
                end
            end
            ST_DIV:
            begin
                rem_next = q_bit ? trial[wfrm_pkg::SUM_W-1:0] :
                           {rem_reg[wfrm_pkg::SUM_W-2:0], quo_reg[wfrm_pkg::NUM_W-1]};
                quo_next = {quo_reg[wfrm_pkg::NUM_W-2:0], q_bit};
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - wfrm_pkg::CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = wfrm_pkg::OUT_TDATA_W'({grade, life_reg, dt_reg, rate});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            life_reg     <= '0;
            sum_reg      <= '0;
            bad_reg      <= wfrm_pkg::BAD_RATE_RESET;
            warn_reg     <= wfrm_pkg::WARN_RATE_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            life_reg     <= life_next;
            sum_reg      <= sum_next;
            bad_reg      <= bad_next;
            warn_reg     <= warn_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        dt_reg     <= dt_next;
        add_sh_reg <= add_sh_next;
        sub_sh_reg <= sub_sh_next;
        carry_reg  <= carry_next;
        borrow_reg <= borrow_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    // Duration ring
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            ring_mem[slot_reg] <= dt_in;
        end
    end

endmodule

[design/wfrm_checker.sv]
module wfrm_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wfrm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic [wfrm_pkg::GRADE_W-1:0] grade_f;
    logic [wfrm_pkg::TOTAL_W-1:0] total_f;

    assign grade_f = m_tdata[wfrm_pkg::GRADE_LSB +: wfrm_pkg::GRADE_W];
    assign total_f = m_tdata[wfrm_pkg::TOTAL_LSB +: wfrm_pkg::TOTAL_W];

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One word in flight: ready drops right after acceptance
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // Grade is one of the three levels
    a_grade: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (grade_f == wfrm_pkg::GRADE_GOOD) || (grade_f == wfrm_pkg::GRADE_WARN)
                     || (grade_f == wfrm_pkg::GRADE_BAD))
        else $error("grade out of range");

    // Every result counts at least its own frame
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> total_f != '0)
        else $error("zero lifetime count on a result");

endmodule

bind windowed_frame_rate_meter wfrm_checker u_wfrm_checker (.*);
